// ----- rtl/rv32id_pkg.sv -----
// Shared types and encodings for the RV32IM instruction decoder.
// No dependencies; imported by rv32id_decode and rv32im_instruction_decoder.
package rv32id_pkg;

   localparam int unsigned INSTR_W = 32;
   localparam int unsigned RSP_DATA_W = 48;

   typedef logic [INSTR_W-1:0] instr_type;

   typedef struct packed {
      logic               valid_res;
      logic [5:0]         mnemonic;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic signed [20:0] immediate;
   } dec_res_type;

   // major opcodes
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_JAL    = 7'h6f;

   // funct7 codes
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;

   // funct3 codes
   localparam logic [2:0] F3_0 = 3'd0;
   localparam logic [2:0] F3_1 = 3'd1;
   localparam logic [2:0] F3_2 = 3'd2;
   localparam logic [2:0] F3_3 = 3'd3;
   localparam logic [2:0] F3_4 = 3'd4;
   localparam logic [2:0] F3_5 = 3'd5;
   localparam logic [2:0] F3_6 = 3'd6;
   localparam logic [2:0] F3_7 = 3'd7;

   // mnemonic numbers
   localparam logic [5:0] MN_ADD   = 6'd0;
   localparam logic [5:0] MN_MUL   = 6'd1;
   localparam logic [5:0] MN_SUB   = 6'd2;
   localparam logic [5:0] MN_SLL   = 6'd3;
   localparam logic [5:0] MN_MULH  = 6'd4;
   localparam logic [5:0] MN_SLT   = 6'd5;
   localparam logic [5:0] MN_SLTU  = 6'd6;
   localparam logic [5:0] MN_XOR   = 6'd7;
   localparam logic [5:0] MN_DIV   = 6'd8;
   localparam logic [5:0] MN_SRL   = 6'd9;
   localparam logic [5:0] MN_SRA   = 6'd10;
   localparam logic [5:0] MN_OR    = 6'd11;
   localparam logic [5:0] MN_REM   = 6'd12;
   localparam logic [5:0] MN_AND   = 6'd13;
   localparam logic [5:0] MN_ADDI  = 6'd14;
   localparam logic [5:0] MN_SLLI  = 6'd15;
   localparam logic [5:0] MN_SLTI  = 6'd16;
   localparam logic [5:0] MN_SLTIU = 6'd17;
   localparam logic [5:0] MN_XORI  = 6'd18;
   localparam logic [5:0] MN_SRLI  = 6'd19;
   localparam logic [5:0] MN_SRAI  = 6'd20;
   localparam logic [5:0] MN_ORI   = 6'd21;
   localparam logic [5:0] MN_ANDI  = 6'd22;
   localparam logic [5:0] MN_LB    = 6'd23;
   localparam logic [5:0] MN_LH    = 6'd24;
   localparam logic [5:0] MN_LW    = 6'd25;
   localparam logic [5:0] MN_LBU   = 6'd26;
   localparam logic [5:0] MN_LHU   = 6'd27;
   localparam logic [5:0] MN_SB    = 6'd28;
   localparam logic [5:0] MN_SH    = 6'd29;
   localparam logic [5:0] MN_SW    = 6'd30;
   localparam logic [5:0] MN_BEQ   = 6'd31;
   localparam logic [5:0] MN_BNE   = 6'd32;
   localparam logic [5:0] MN_BLT   = 6'd33;
   localparam logic [5:0] MN_BGE   = 6'd34;
   localparam logic [5:0] MN_BLTU  = 6'd35;
   localparam logic [5:0] MN_BGEU  = 6'd36;
   localparam logic [5:0] MN_AUIPC = 6'd37;
   localparam logic [5:0] MN_LUI   = 6'd38;
   localparam logic [5:0] MN_JAL   = 6'd39;
   localparam logic [5:0] MN_JALR  = 6'd40;
   localparam logic [5:0] MN_ECALL = 6'd41;

endpackage

// ----- rtl/rv32id_decode.sv -----
// Combinational RV32IM decode of one instruction word into a dec_res_type.
// Depends on rv32id_pkg.
module rv32id_decode (
   input  rv32id_pkg::instr_type   instr,
   output rv32id_pkg::dec_res_type res
);
   import rv32id_pkg::*;

   logic [6:0]         op;
   logic [2:0]         f3;
   logic [6:0]         f7;
   logic               ok;
   logic [5:0]         mn;
   logic [4:0]         rd;
   logic [4:0]         rs1;
   logic [4:0]         rs2;
   logic signed [20:0] imm;
   logic signed [20:0] imm_i;
   logic signed [20:0] imm_s;
   logic signed [20:0] imm_b;
   logic signed [20:0] imm_j;
   logic signed [20:0] imm_u;

   assign op = instr[6:0];
   assign f3 = instr[14:12];
   assign f7 = instr[31:25];

   assign imm_i = {{9{instr[31]}}, instr[31:20]};
   assign imm_s = {{9{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{8{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign imm_u = {1'b0, instr[31:12]};

   always_comb begin
      ok  = 1'b0;
      mn  = MN_ADD;
      rd  = '0;
      rs1 = '0;
      rs2 = '0;
      imm = '0;
      unique case (op)
         OP_REG: begin
            rd  = instr[11:7];
            rs1 = instr[19:15];
            rs2 = instr[24:20];
            ok  = 1'b1;
            if (f7 == F7_BASE) begin
               unique case (f3)
                  F3_0: mn = MN_ADD;
                  F3_1: mn = MN_SLL;
                  F3_2: mn = MN_SLT;
                  F3_3: mn = MN_SLTU;
                  F3_4: mn = MN_XOR;
                  F3_5: mn = MN_SRL;
                  F3_6: mn = MN_OR;
                  default: mn = MN_AND;
               endcase
            end else if (f7 == F7_MULDIV) begin
               unique case (f3)
                  F3_0: mn = MN_MUL;
                  F3_1: mn = MN_MULH;
                  F3_4: mn = MN_DIV;
                  F3_6: mn = MN_REM;
                  default: ok = 1'b0;
               endcase
            end else if (f7 == F7_ALT) begin
               unique case (f3)
                  F3_0: mn = MN_SUB;
                  F3_5: mn = MN_SRA;
                  default: ok = 1'b0;
               endcase
            end else begin
               ok = 1'b0;
            end
         end
         OP_IMM: begin
            rd  = instr[11:7];
            rs1 = instr[19:15];
            imm = imm_i;
            ok  = 1'b1;
            unique case (f3)
               F3_0: mn = MN_ADDI;
               F3_1: begin
                  mn = MN_SLLI;
                  ok = (f7 == F7_BASE);
               end
               F3_2: mn = MN_SLTI;
               F3_3: mn = MN_SLTIU;
               F3_4: mn = MN_XORI;
               F3_5: begin
                  if (f7 == F7_BASE) begin
                     mn = MN_SRLI;
                  end else if (f7 == F7_ALT) begin
                     mn = MN_SRAI;
                  end else begin
                     ok = 1'b0;
                  end
               end
               F3_6: mn = MN_ORI;
               default: mn = MN_ANDI;
            endcase
         end
         OP_LOAD: begin
            rd  = instr[11:7];
            rs1 = instr[19:15];
            imm = imm_i;
            ok  = 1'b1;
            unique case (f3)
               F3_0: mn = MN_LB;
               F3_1: mn = MN_LH;
               F3_2: mn = MN_LW;
               F3_4: mn = MN_LBU;
               F3_5: mn = MN_LHU;
               default: ok = 1'b0;
            endcase
         end
         OP_JALR: begin
            rd  = instr[11:7];
            rs1 = instr[19:15];
            imm = imm_i;
            mn  = MN_JALR;
            ok  = (f3 == F3_0);
         end
         OP_SYSTEM: begin
            mn = MN_ECALL;
            ok = (f3 == F3_0) && (instr[31:20] == '0);
         end
         OP_STORE: begin
            rs1 = instr[19:15];
            rs2 = instr[24:20];
            imm = imm_s;
            ok  = 1'b1;
            unique case (f3)
               F3_0: mn = MN_SB;
               F3_1: mn = MN_SH;
               F3_2: mn = MN_SW;
               default: ok = 1'b0;
            endcase
         end
         OP_BRANCH: begin
            rs1 = instr[19:15];
            rs2 = instr[24:20];
            imm = imm_b;
            ok  = 1'b1;
            unique case (f3)
               F3_0: mn = MN_BEQ;
               F3_1: mn = MN_BNE;
               F3_4: mn = MN_BLT;
               F3_5: mn = MN_BGE;
               F3_6: mn = MN_BLTU;
               F3_7: mn = MN_BGEU;
               default: ok = 1'b0;
            endcase
         end
         OP_AUIPC: begin
            rd  = instr[11:7];
            imm = imm_u;
            mn  = MN_AUIPC;
            ok  = 1'b1;
         end
         OP_LUI: begin
            rd  = instr[11:7];
            imm = imm_u;
            mn  = MN_LUI;
            ok  = 1'b1;
         end
         OP_JAL: begin
            rd  = instr[11:7];
            imm = imm_j;
            mn  = MN_JAL;
            ok  = 1'b1;
         end
         default: ok = 1'b0;
      endcase

      // unrecognised words report all-zero
      if (ok) begin
         res.valid_res = 1'b1;
         res.mnemonic  = mn;
         res.dest_reg  = rd;
         res.src1_reg  = rs1;
         res.src2_reg  = rs2;
         res.immediate = imm;
      end else begin
         res = '0;
      end
   end

endmodule

// ----- rtl/rv32im_instruction_decoder.sv -----
// RV32IM instruction decoder, top level: input register, decode, result register.
// Depends on rv32id_pkg and rv32id_decode.
// An accepted request word passes through the input register, then the result register, to the response.
// Throughput: one word per cycle; both stages advance whenever the result
// register is empty or being taken. A held response stalls intake once the
// input register is full as well.
// Reset (synchronous, active high) empties both stages; no other state.
module rv32im_instruction_decoder (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  rv32id_pkg::instr_type                    req_tdata,  // [31:0] instruction
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [rv32id_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [5:0] mnemonic, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
   // [41:21] immediate, [47:42] zero
   output logic                                     rsp_tuser   // [0] valid_res
);
   import rv32id_pkg::*;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   instr_type   s1_instr_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   dec_res_type out_res_ff;
   dec_res_type dec_res;
   logic        out_load;
   logic        req_take;

   rv32id_decode u_decode (
      .instr (s1_instr_ff),
      .res   (dec_res)
   );

   assign out_load   = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_instr_ff <= req_tdata;
      end
      if (out_load) begin
         out_res_ff <= dec_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.valid_res;
   assign rsp_tdata  = {6'b0,
                        out_res_ff.immediate,
                        out_res_ff.src2_reg,
                        out_res_ff.src1_reg,
                        out_res_ff.dest_reg,
                        out_res_ff.mnemonic};

endmodule
